// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertions on clk_i with reset rst_ni masking the check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside reset.
`define IIRTDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that cond never holds outside reset.
`define IIRTDF_ASSERT_NEVER(label, cond, msg) \
  `IIRTDF_ASSERT(label, !(cond), msg)

`endif

// ===== design/iirtdf_pkg.sv =====
// ----------------------------------------------------------------------------
// IIR TDF-II package
// Item types, command codes and saturation helper shared by the filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iirtdf_pkg;

  localparam int NREGS     = 5;
  localparam int REG_W     = 48;
  localparam int COEF_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int SAMPLE_W  = 16;
  localparam int DELAY_W   = 48;
  localparam int FRAC      = 20;
  localparam int OPND_W    = DELAY_W - FRAC;
  localparam int PROD_W    = COEF_W + OPND_W;
  localparam int ACC_W     = PROD_W + 2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [REG_W-1:0]     value;
  } cfg_item_t;

  typedef enum logic [1:0] {
    MUL_BX  = 2'd0,
    MUL_AHI = 2'd1,
    MUL_ALO = 2'd2
  } mul_op_e;

  typedef enum logic [2:0] {
    ACC_NONE = 3'd0,
    ACC_Y    = 3'd1,
    ACC_LOAD = 3'd2,
    ACC_SUB  = 3'd3,
    ACC_FIN  = 3'd4
  } acc_op_e;

  typedef struct packed {
    logic    load_x;
    mul_op_e mul_op;
    acc_op_e acc_op;
    logic    rd_en;
    logic    out_load;
  } cmd_t;

  function automatic logic signed [DELAY_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic signed [DELAY_W-1:0] r;
    if (v[ACC_W-1:DELAY_W-1] == '0 || v[ACC_W-1:DELAY_W-1] == '1) begin
      r = v[DELAY_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(DELAY_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DELAY_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== design/iirtdf_stream_if.sv =====
// ----------------------------------------------------------------------------
// IIR TDF-II stream interface
// Valid/ready channel carrying one item of type payload_t.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface iirtdf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/iirtdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// IIR TDF-II controller
// Sequences the shared multiplier and accumulator through all taps of one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iirtdf_ctrl #(
  parameter int TAPS = 5,
  parameter int TW   = $clog2(TAPS),
  parameter int DW   = (TAPS > 2) ? $clog2(TAPS - 1) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output iirtdf_pkg::cmd_t  cmd_o,
  output logic [TW-1:0]     tap_o,
  output logic [DW-1:0]     wr_idx_o
);
  import iirtdf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_MUL_B0   = 7'b0000010,
    S_MUL_BX   = 7'b0000100,
    S_MUL_AHI  = 7'b0001000,
    S_MUL_ALO  = 7'b0010000,
    S_FIN_LAST = 7'b0100000,
    S_HOLD     = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic [TW-1:0] tap_q, tap_d;
  logic          out_valid_q, out_valid_d;
  logic [TW-1:0] wr_full;
  logic          out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    tap_d         = tap_q;
    cmd_o         = '0;
    cmd_o.mul_op  = MUL_BX;
    cmd_o.acc_op  = ACC_NONE;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.load_x = in_valid_i;
        tap_d        = '0;
        if (in_valid_i) begin
          state_d = S_MUL_B0;
        end
      end
      S_MUL_B0: begin
        tap_d   = TW'(1);
        state_d = S_MUL_BX;
      end
      S_MUL_BX: begin
        cmd_o.acc_op = (tap_q == TW'(1)) ? ACC_Y : ACC_FIN;
        state_d      = S_MUL_AHI;
      end
      S_MUL_AHI: begin
        cmd_o.mul_op = MUL_AHI;
        cmd_o.acc_op = ACC_LOAD;
        cmd_o.rd_en  = (tap_q < TW'(TAPS - 1));
        state_d      = S_MUL_ALO;
      end
      S_MUL_ALO: begin
        cmd_o.mul_op = MUL_ALO;
        cmd_o.acc_op = ACC_SUB;
        if (tap_q == TW'(TAPS - 1)) begin
          state_d = S_FIN_LAST;
        end else begin
          tap_d   = tap_q + TW'(1);
          state_d = S_MUL_BX;
        end
      end
      S_FIN_LAST: begin
        cmd_o.acc_op = ACC_FIN;
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (state_q == S_FIN_LAST) begin
      wr_full = tap_q - TW'(1);
    end else begin
      wr_full = tap_q - TW'(1) - TW'(1);
    end
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign tap_o       = tap_q;
  assign wr_idx_o    = wr_full[DW-1:0];
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/iirtdf_datapath.sv =====
// ----------------------------------------------------------------------------
// IIR TDF-II datapath
// Coefficient registers, delay terms, shared multiplier and accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iirtdf_datapath #(
  parameter int TAPS = 5,
  parameter int TW   = $clog2(TAPS),
  parameter int DW   = (TAPS > 2) ? $clog2(TAPS - 1) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  iirtdf_pkg::cmd_t                cmd_i,
  input  logic [TW-1:0]                   tap_i,
  input  logic [DW-1:0]                   wr_idx_i,
  input  logic signed [iirtdf_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic                            cfg_valid_i,
  input  iirtdf_pkg::cfg_item_t           cfg_data_i,
  output iirtdf_pkg::out_item_t           out_data_o
);
  import iirtdf_pkg::*;

  logic        [REG_W-1:0]    coef_q [NREGS];
  logic signed [DELAY_W-1:0]  d_q    [TAPS-1];
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [DELAY_W-1:0]  y_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  out_item_t                  out_q;

  logic signed [COEF_W-1:0]   coef_b, coef_a, coef_sel;
  logic signed [OPND_W-1:0]   opnd_sel;
  logic signed [DELAY_W-1:0]  d_rd;
  logic signed [ACC_W-1:0]    fin_v;
  logic signed [OPND_W-1:0]   q_trunc;

  // Coefficient lookup; taps past the register file read as zero
  always_comb begin
    coef_b = '0;
    coef_a = '0;
    for (int k = 0; k < NREGS; k++) begin
      if (32'(tap_i) == k) begin
        coef_b = coef_q[k][REG_W-1:COEF_W];
        coef_a = coef_q[k][COEF_W-1:0];
      end
    end
  end

  always_comb begin
    case (cmd_i.mul_op)
      MUL_AHI: begin
        coef_sel = coef_a;
        opnd_sel = y_q[DELAY_W-1:FRAC];
      end
      MUL_ALO: begin
        coef_sel = coef_a;
        opnd_sel = {{(OPND_W-FRAC){1'b0}}, y_q[FRAC-1:0]};
      end
      default: begin
        coef_sel = coef_b;
        opnd_sel = OPND_W'(x_q);
      end
    endcase
  end

  assign prod_d = coef_sel * opnd_sel;
  assign d_rd   = cmd_i.rd_en ? d_q[tap_i[DW-1:0]] : '0;
  assign fin_v  = acc_q - ACC_W'(prod_q >>> FRAC);

  // Truncate toward zero: floor plus one for negative values with a fraction
  assign q_trunc = y_q[DELAY_W-1:FRAC]
                 + OPND_W'({1'b0, y_q[DELAY_W-1] & (|y_q[FRAC-1:0])});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NREGS; k++) begin
        coef_q[k] <= '0;
      end
      for (int k = 0; k < TAPS - 1; k++) begin
        d_q[k] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_data_i.index < CFG_IDX_W'(NREGS)) begin
        coef_q[cfg_data_i.index] <= cfg_data_i.value;
      end
      if (cmd_i.acc_op == ACC_FIN) begin
        d_q[wr_idx_i] <= sat48(fin_v);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load_x) begin
      x_q <= sample_in_i;
    end
    case (cmd_i.acc_op)
      ACC_Y:    y_q   <= sat48(ACC_W'(prod_q) + ACC_W'(d_q[0]));
      ACC_LOAD: acc_q <= ACC_W'(prod_q) + ACC_W'(d_rd);
      ACC_SUB:  acc_q <= acc_q - ACC_W'(prod_q);
      default:  ;
    endcase
    if (cmd_i.out_load) begin
      if (q_trunc[OPND_W-1:SAMPLE_W-1] == '0 || q_trunc[OPND_W-1:SAMPLE_W-1] == '1) begin
        out_q.sample_out <= q_trunc[SAMPLE_W-1:0];
        out_q.clipped    <= 1'b0;
      end else begin
        out_q.sample_out <= q_trunc[OPND_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                              : {1'b0, {(SAMPLE_W-1){1'b1}}};
        out_q.clipped    <= 1'b1;
      end
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== design/iir_transposed_direct_form_two_filter.sv =====
// Items are taken one at a time: a new item is accepted only after the last
// result has been loaded into the output register. The single shared
// multiplier forms three products per tap plus b0*x.
// Reset: clears coefficients, delay terms and control at once; no clearing pass.
// ----------------------------------------------------------------------------
// IIR filter, transposed direct form II
// Fixed-point order TAPS-1 filter with saturated 16-bit output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iir_transposed_direct_form_two_filter #(
  parameter int TAPS = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  iirtdf_stream_if.sink   in_if,
  iirtdf_stream_if.source out_if,
  iirtdf_stream_if.sink   cfg_if
);
  import iirtdf_pkg::*;

  localparam int TW = $clog2(TAPS);
  localparam int DW = (TAPS > 2) ? $clog2(TAPS - 1) : 1;

  cmd_t          cmd;
  logic [TW-1:0] tap;
  logic [DW-1:0] wr_idx;
  in_item_t      in_item;
  cfg_item_t     cfg_item;
  out_item_t     out_item;

  assign in_item    = in_if.data;
  assign cfg_item   = cfg_if.data;
  assign cfg_if.ready = 1'b1;
  assign out_if.data  = out_item;

  iirtdf_ctrl #(
    .TAPS (TAPS),
    .TW   (TW),
    .DW   (DW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .tap_o       (tap),
    .wr_idx_o    (wr_idx)
  );

  iirtdf_datapath #(
    .TAPS (TAPS),
    .TW   (TW),
    .DW   (DW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .tap_i       (tap),
    .wr_idx_i    (wr_idx),
    .sample_in_i (in_item.sample_in),
    .cfg_valid_i (cfg_if.valid),
    .cfg_data_i  (cfg_item),
    .out_data_o  (out_item)
  );

endmodule

// ===== design/iirtdf_checker.sv =====
// ----------------------------------------------------------------------------
// IIR TDF-II port checker
// Port-level checks on the filter's channels, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iirtdf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] sample_out_i,
  input logic        clipped_i,
  input logic        cfg_valid_i,
  input logic        cfg_ready_i
);

  `IIRTDF_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(sample_out_i) && $stable(clipped_i), "stalled result item changed")
  `IIRTDF_ASSERT(a_busy_after_accept, in_valid_i && in_ready_i |=> !in_ready_i, "accepted a second item while busy")
  `IIRTDF_ASSERT(a_result_when_idle, $rose(out_valid_i) |-> in_ready_i, "result appeared while item still in work")
  `IIRTDF_ASSERT(a_clip_rail, out_valid_i && clipped_i |-> sample_out_i == 16'h7FFF || sample_out_i == 16'h8000, "clipped item not at a rail")
  `IIRTDF_ASSERT_NEVER(a_cfg_ready, cfg_valid_i && !cfg_ready_i, "configuration write stalled")

endmodule

bind iir_transposed_direct_form_two_filter iirtdf_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .sample_out_i (out_if.data.sample_out),
  .clipped_i    (out_if.data.clipped),
  .cfg_valid_i  (cfg_if.valid),
  .cfg_ready_i  (cfg_if.ready)
);
